@@ hdl/ray_box_slab_test_defines.svh @@
// assertion macros for the ray/box slab test block
// used by the top level only, expects clk_i and rst_ni in scope
`ifndef RAY_BOX_SLAB_TEST_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_DEFINES_SVH
`ifndef SYNTH
`define RBST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RBST_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RBST_ASSERT(lbl, prop, msg)
`define RBST_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ hdl/rbst_pkg.sv @@
// shared constants, register codes and status structs of the slab test block
// no dependencies
`default_nettype none
package rbst_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS = 16;
  // reciprocal quotient of 2^(2*frac) has one bit more than 2*frac
  localparam int QUO_W = 2 * FRAC_BITS + 1;
  localparam int MUL_W = 32;
  localparam int QDEPTH = 2;
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LO_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LO_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LO_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HI_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HI_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HI_Z = 3'd5;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] count;
  } qstat_t;

  typedef struct packed {
    logic valid;
    logic push;
  } fctl_t;

  // per axis: zero, neg, inside flags plus magnitude and two differences
  function automatic int item_width(int w);
    return 11 * w + 9;
  endfunction
endpackage
`default_nettype wire

@@ hdl/rbst_if.sv @@
// ray and hit channel interfaces, valid/ready with payload
// no dependencies
`default_nettype none
interface rbst_ray_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] origin_x;
  logic signed [W-1:0] origin_y;
  logic signed [W-1:0] origin_z;
  logic signed [W-1:0] dir_x;
  logic signed [W-1:0] dir_y;
  logic signed [W-1:0] dir_z;
  logic signed [W-1:0] t_near;
  logic signed [W-1:0] t_far;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  t_near, t_far, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                t_near, t_far, output ready);
endinterface

interface rbst_hit_if;
  logic valid;
  logic ready;
  logic hit;
  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface
`default_nettype wire

@@ hdl/rbst_front.sv @@
// front end: takes a ray, classifies each axis, forms saturated bound differences
// depends on rbst_pkg and rbst_if
`default_nettype none
module rbst_front #(
  parameter int W = rbst_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  rbst_ray_if.sink                                  ray,
  input  wire logic [2:0][W-1:0]                    lo_i,
  input  wire logic [2:0][W-1:0]                    hi_i,
  input  wire rbst_pkg::qstat_t                     qstat_i,
  output rbst_pkg::fctl_t                           fctl_o,
  output logic [rbst_pkg::item_width(W)-1:0]        item_o
);
  import rbst_pkg::*;

  typedef struct packed {
    logic                zero;
    logic                neg;
    logic                in_slab;
    logic [W-1:0]        dmag;
    logic signed [W-1:0] dnear;
    logic signed [W-1:0] dfar;
  } axis_t;

  typedef struct packed {
    axis_t [2:0]         ax;
    logic signed [W-1:0] t_near;
    logic signed [W-1:0] t_far;
  } item_t;

  localparam logic [W-1:0] MinV = W'(1) << (W - 1);
  localparam logic [W-1:0] MaxV = MinV - W'(1);

  function automatic logic signed [W-1:0] sat_sub(logic signed [W-1:0] a,
                                                   logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) begin
      sat_sub = s[W] ? MinV : MaxV;
    end else begin
      sat_sub = s[W-1:0];
    end
  endfunction

  logic signed [W-1:0] org [3];
  logic signed [W-1:0] dir [3];
  item_t item_d, item_q;
  logic  front_v_q;
  logic  push;

  assign org[0] = ray.origin_x;
  assign org[1] = ray.origin_y;
  assign org[2] = ray.origin_z;
  assign dir[0] = ray.dir_x;
  assign dir[1] = ray.dir_y;
  assign dir[2] = ray.dir_z;

  always_comb begin
    logic signed [W-1:0] lo, hi;
    for (int a = 0; a < 3; a++) begin
      lo = $signed(lo_i[a]);
      hi = $signed(hi_i[a]);
      item_d.ax[a].zero    = (dir[a] == '0);
      item_d.ax[a].neg     = dir[a][W-1];
      item_d.ax[a].in_slab = (lo <= org[a]) && (org[a] <= hi);
      item_d.ax[a].dmag    = dir[a][W-1] ? W'(-dir[a]) : dir[a];
      // negative direction swaps which bound is entered first
      item_d.ax[a].dnear   = sat_sub(dir[a][W-1] ? hi : lo, org[a]);
      item_d.ax[a].dfar    = sat_sub(dir[a][W-1] ? lo : hi, org[a]);
    end
    item_d.t_near = ray.t_near;
    item_d.t_far  = ray.t_far;
  end

  assign push      = front_v_q && !qstat_i.full;
  assign ray.ready = !front_v_q || push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_v_q <= 1'b0;
    end else if (ray.valid && ray.ready) begin
      front_v_q <= 1'b1;
    end else if (push) begin
      front_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ray.valid && ray.ready) begin
      item_q <= item_d;
    end
  end

  assign fctl_o.valid = front_v_q;
  assign fctl_o.push  = push;
  assign item_o       = item_q;
endmodule
`default_nettype wire

@@ hdl/rbst_queue.sv @@
// short queue between the front end and the arithmetic back end
// depends on rbst_pkg
`default_nettype none
module rbst_queue #(
  parameter int DATA_W = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rbst_pkg::fctl_t   fctl_i,
  input  wire logic [DATA_W-1:0] data_i,
  input  wire logic              pop_i,
  output rbst_pkg::qstat_t       qstat_o,
  output logic [DATA_W-1:0]      data_o
);
  import rbst_pkg::*;

  localparam int PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  logic [DATA_W-1:0] mem_q [QDEPTH];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(QDEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (fctl_i.push) begin
        wr_q <= next_ptr(wr_q);
      end
      if (pop_i) begin
        rd_q <= next_ptr(rd_q);
      end
      if (fctl_i.push && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (!fctl_i.push && pop_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fctl_i.push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o        = mem_q[rd_q];
  assign qstat_o.full  = (cnt_q == CNT_W'(QDEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign qstat_o.count = cnt_q;
endmodule
`default_nettype wire

@@ hdl/rbst_recip.sv @@
// pipelined restoring divider: 2^(2*frac) / divisor, one quotient bit per stage
// depends on rbst_pkg
`default_nettype none
module rbst_recip #(
  parameter int W = rbst_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [W-1:0]               div_i,
  output logic [rbst_pkg::QUO_W-1:0]      quo_o
);
  import rbst_pkg::*;

  logic [W-1:0]     rem_q [QUO_W];
  logic [W-1:0]     rem_d [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [QUO_W-1:0] quo_d [QUO_W];
  logic [W-1:0]     div_q [QUO_W];
  logic [W-1:0]     div_d [QUO_W];

  always_comb begin
    logic [W-1:0]     rin, din;
    logic [QUO_W-1:0] qin;
    logic [W:0]       trial;
    logic             ge;
    for (int s = 0; s < QUO_W; s++) begin
      rin = (s == 0) ? '0 : rem_q[(s == 0) ? 0 : s - 1];
      qin = (s == 0) ? '0 : quo_q[(s == 0) ? 0 : s - 1];
      din = (s == 0) ? div_i : div_q[(s == 0) ? 0 : s - 1];
      // the dividend has a single one, at its top bit
      trial    = {rin, (s == 0)};
      ge       = trial >= {1'b0, din};
      rem_d[s] = ge ? W'(trial - {1'b0, din}) : trial[W-1:0];
      quo_d[s] = {qin[QUO_W-2:0], ge};
      div_d[s] = din;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QUO_W; s++) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        div_q[s] <= div_d[s];
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];
endmodule
`default_nettype wire

@@ hdl/rbst_back.sv @@
// back end: reciprocals, slab products, interval narrowing and the hit register
// depends on rbst_pkg, rbst_if and rbst_recip
`default_nettype none
module rbst_back #(
  parameter int W = rbst_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [rbst_pkg::item_width(W)-1:0] item_i,
  input  wire rbst_pkg::qstat_t               qstat_i,
  output logic                                pop_o,
  rbst_hit_if.source                          hit
);
  import rbst_pkg::*;

  localparam int NA  = (W + MUL_W - 1) / MUL_W;
  localparam int APW = NA * MUL_W;
  localparam int BW  = QUO_W - 1;
  localparam int PPW = MUL_W + BW;
  localparam int PW  = APW + QUO_W;
  localparam int XW  = ((W > QUO_W) ? W : QUO_W) + 1;

  localparam logic [W-1:0]  MinV = W'(1) << (W - 1);
  localparam logic [W-1:0]  MaxV = MinV - W'(1);
  localparam logic [XW-1:0] CapN = XW'(1) << (W - 1);
  localparam logic [XW-1:0] CapP = CapN - XW'(1);
  localparam logic [PW-1:0] LimN = PW'(1) << (W - 1);
  localparam logic [PW-1:0] LimP = LimN - PW'(1);

  typedef struct packed {
    logic                zero;
    logic                neg;
    logic                in_slab;
    logic [W-1:0]        dmag;
    logic signed [W-1:0] dnear;
    logic signed [W-1:0] dfar;
  } axis_t;

  typedef struct packed {
    axis_t [2:0]         ax;
    logic signed [W-1:0] t_near;
    logic signed [W-1:0] t_far;
  } item_t;

  typedef struct packed {
    logic             zero;
    logic             in_slab;
    logic             neg_n;
    logic             neg_f;
    logic [QUO_W-1:0] invm;
    logic [W-1:0]     an;
    logic [W-1:0]     af;
  } ax1_t;

  typedef struct packed {
    logic                     zero;
    logic                     in_slab;
    logic                     neg_n;
    logic                     neg_f;
    logic [NA-1:0][PPW-1:0]   ppn;
    logic [NA-1:0][PPW-1:0]   ppf;
    logic [W-1:0]             xn;
    logic [W-1:0]             xf;
  } ax2_t;

  typedef struct packed {
    logic          zero;
    logic          in_slab;
    logic          neg_n;
    logic          neg_f;
    logic [PW-1:0] pn;
    logic [PW-1:0] pf;
  } ax3_t;

  typedef struct packed {
    logic                zero;
    logic                in_slab;
    logic signed [W-1:0] tmin;
    logic signed [W-1:0] tmax;
  } ax4_t;

  typedef struct packed {
    logic signed [W-1:0] tmin;
    logic signed [W-1:0] tmax;
    logic                miss;
  } span_t;

  item_t               head;
  logic                en;
  logic [QUO_W-1:0]    quo [3];

  item_t               dly_q [QUO_W];
  logic [QUO_W-1:0]    dv_q;
  ax1_t [2:0]          s1_d, s1_q;
  ax2_t [2:0]          s2_d, s2_q;
  ax3_t [2:0]          s3_d, s3_q;
  ax4_t [2:0]          s4_d, s4_q;
  logic signed [W-1:0] tn_q [4];
  logic signed [W-1:0] tf_q [4];
  span_t               s5_d, s5_q, s6_d, s6_q;
  ax4_t                z5_q;
  logic signed [W-1:0] tn5_q, tf5_q, tn6_q, tf6_q;
  logic                v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic                out_v_q, hit_q, hit_d;

  assign head  = item_i;
  // whole back end moves as one when the output register can take a result
  assign en    = !out_v_q || hit.ready;
  assign pop_o = en && !qstat_i.empty;

  for (genvar a = 0; a < 3; a++) begin : g_recip
    rbst_recip #(.W(W)) u_recip (
      .clk_i (clk_i),
      .en_i  (en),
      .div_i (head.ax[a].dmag),
      .quo_o (quo[a])
    );
  end

  function automatic logic [W-1:0] absv(logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : v;
  endfunction

  function automatic logic signed [W-1:0] sat_prod(logic neg, logic [PW-1:0] p);
    logic [PW-1:0] sh;
    sh = p >> FRAC_BITS;
    if (!neg) begin
      sat_prod = (sh > LimP) ? MaxV : sh[W-1:0];
    end else begin
      sat_prod = (sh > LimN) ? MinV : W'(-sh[W-1:0]);
    end
  endfunction

  // stage 1: clamp reciprocal magnitude, split differences into sign and magnitude
  always_comb begin
    item_t         it;
    logic [XW-1:0] qx, cap;
    it = dly_q[QUO_W-1];
    for (int a = 0; a < 3; a++) begin
      qx  = XW'(quo[a]);
      cap = it.ax[a].neg ? CapN : CapP;
      s1_d[a].zero    = it.ax[a].zero;
      s1_d[a].in_slab = it.ax[a].in_slab;
      s1_d[a].invm    = (qx > cap) ? cap[QUO_W-1:0] : quo[a];
      s1_d[a].neg_n   = it.ax[a].dnear[W-1] ^ it.ax[a].neg;
      s1_d[a].neg_f   = it.ax[a].dfar[W-1] ^ it.ax[a].neg;
      s1_d[a].an      = absv(it.ax[a].dnear);
      s1_d[a].af      = absv(it.ax[a].dfar);
    end
  end

  // stage 2: 32 x 32 partial products
  always_comb begin
    logic [APW-1:0] pa_n, pa_f;
    for (int a = 0; a < 3; a++) begin
      pa_n = APW'(s1_q[a].an);
      pa_f = APW'(s1_q[a].af);
      s2_d[a].zero    = s1_q[a].zero;
      s2_d[a].in_slab = s1_q[a].in_slab;
      s2_d[a].neg_n   = s1_q[a].neg_n;
      s2_d[a].neg_f   = s1_q[a].neg_f;
      for (int k = 0; k < NA; k++) begin
        s2_d[a].ppn[k] = PPW'(pa_n[k*MUL_W +: MUL_W]) * PPW'(s1_q[a].invm[BW-1:0]);
        s2_d[a].ppf[k] = PPW'(pa_f[k*MUL_W +: MUL_W]) * PPW'(s1_q[a].invm[BW-1:0]);
      end
      // top reciprocal bit only set for a unit or zero divisor
      s2_d[a].xn = s1_q[a].invm[BW] ? s1_q[a].an : '0;
      s2_d[a].xf = s1_q[a].invm[BW] ? s1_q[a].af : '0;
    end
  end

  // stage 3: sum partial products
  always_comb begin
    logic [PW-1:0] acc_n, acc_f;
    for (int a = 0; a < 3; a++) begin
      acc_n = PW'(s2_q[a].xn) << BW;
      acc_f = PW'(s2_q[a].xf) << BW;
      for (int k = 0; k < NA; k++) begin
        acc_n = acc_n + (PW'(s2_q[a].ppn[k]) << (k * MUL_W));
        acc_f = acc_f + (PW'(s2_q[a].ppf[k]) << (k * MUL_W));
      end
      s3_d[a].zero    = s2_q[a].zero;
      s3_d[a].in_slab = s2_q[a].in_slab;
      s3_d[a].neg_n   = s2_q[a].neg_n;
      s3_d[a].neg_f   = s2_q[a].neg_f;
      s3_d[a].pn      = acc_n;
      s3_d[a].pf      = acc_f;
    end
  end

  // stage 4: rescale and saturate, parallel slab spans the whole range
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s4_d[a].zero    = s3_q[a].zero;
      s4_d[a].in_slab = s3_q[a].in_slab;
      s4_d[a].tmin    = s3_q[a].zero ? MinV : sat_prod(s3_q[a].neg_n, s3_q[a].pn);
      s4_d[a].tmax    = s3_q[a].zero ? MaxV : sat_prod(s3_q[a].neg_f, s3_q[a].pf);
    end
  end

  // stage 5: narrow x against y
  always_comb begin
    logic rej;
    rej = (s4_q[0].tmin > s4_q[1].tmax) || (s4_q[1].tmin > s4_q[0].tmax);
    s5_d.miss = (s4_q[0].zero && !s4_q[0].in_slab) ||
                (s4_q[1].zero && !s4_q[1].in_slab) || rej;
    s5_d.tmin = (s4_q[1].tmin > s4_q[0].tmin) ? s4_q[1].tmin : s4_q[0].tmin;
    s5_d.tmax = (s4_q[1].tmax < s4_q[0].tmax) ? s4_q[1].tmax : s4_q[0].tmax;
  end

  // stage 6: narrow with z
  always_comb begin
    logic rej;
    rej = (s5_q.tmin > z5_q.tmax) || (z5_q.tmin > s5_q.tmax);
    s6_d.miss = s5_q.miss || (z5_q.zero && !z5_q.in_slab) || rej;
    s6_d.tmin = (z5_q.tmin > s5_q.tmin) ? z5_q.tmin : s5_q.tmin;
    s6_d.tmax = (z5_q.tmax < s5_q.tmax) ? z5_q.tmax : s5_q.tmax;
  end

  assign hit_d = !s6_q.miss && (s6_q.tmin < tf6_q) && (s6_q.tmax > tn6_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q    <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      dv_q    <= {dv_q[QUO_W-2:0], !qstat_i.empty};
      v1_q    <= dv_q[QUO_W-1];
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      out_v_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= head;
      for (int s = 1; s < QUO_W; s++) begin
        dly_q[s] <= dly_q[s-1];
      end
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      s4_q  <= s4_d;
      tn_q[0] <= dly_q[QUO_W-1].t_near;
      tf_q[0] <= dly_q[QUO_W-1].t_far;
      for (int s = 1; s < 4; s++) begin
        tn_q[s] <= tn_q[s-1];
        tf_q[s] <= tf_q[s-1];
      end
      s5_q  <= s5_d;
      z5_q  <= s4_q[2];
      tn5_q <= tn_q[3];
      tf5_q <= tf_q[3];
      s6_q  <= s6_d;
      tn6_q <= tn5_q;
      tf6_q <= tf5_q;
      hit_q <= hit_d;
    end
  end

  assign hit.valid = out_v_q;
  assign hit.hit   = hit_q;
endmodule
`default_nettype wire

@@ hdl/ray_box_slab_test.sv @@
// ray against axis-aligned box, slab method, signed Q16.16 fixed point
// throughput: one ray per cycle while the output is not stalled, set by the
// 33-stage pipelined reciprocal divider
// reset: asynchronous active low, clears all valid state and the box corners to zero
// a stalled output holds the whole back end; the front end fills a two-entry queue
`default_nettype none
`include "ray_box_slab_test_defines.svh"
module ray_box_slab_test #(
  parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  rbst_ray_if.sink                               ray_i,
  rbst_hit_if.source                             hit_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [rbst_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [COORD_WIDTH-1:0]            cfg_data_i
);
  import rbst_pkg::*;

  localparam int ItemW = item_width(COORD_WIDTH);

  logic [2:0][COORD_WIDTH-1:0] lo_q, hi_q;
  fctl_t                       fctl;
  qstat_t                      q_stat;
  logic [ItemW-1:0]            front_item, head_item;
  logic                        pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LO_X: lo_q[0] <= cfg_data_i;
        REG_LO_Y: lo_q[1] <= cfg_data_i;
        REG_LO_Z: lo_q[2] <= cfg_data_i;
        REG_HI_X: hi_q[0] <= cfg_data_i;
        REG_HI_Y: hi_q[1] <= cfg_data_i;
        REG_HI_Z: hi_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rbst_front #(.W(COORD_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ray     (ray_i),
    .lo_i    (lo_q),
    .hi_i    (hi_q),
    .qstat_i (q_stat),
    .fctl_o  (fctl),
    .item_o  (front_item)
  );

  rbst_queue #(.DATA_W(ItemW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fctl_i  (fctl),
    .data_i  (front_item),
    .pop_i   (pop),
    .qstat_o (q_stat),
    .data_o  (head_item)
  );

  rbst_back #(.W(COORD_WIDTH)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (head_item),
    .qstat_i (q_stat),
    .pop_o   (pop),
    .hit     (hit_o)
  );

  `RBST_ASSERT(a_no_overflow, q_stat.full |-> !fctl.push, "queue push while full")
  `RBST_ASSERT(a_count_range, q_stat.count <= CNT_W'(QDEPTH), "queue count out of range")
  `RBST_ASSERT(a_pop_nonempty, pop |-> !q_stat.empty, "queue pop while empty")
  `RBST_ASSERT_RST(a_reset_quiet, !rst_ni |=> !hit_o.valid, "result valid after reset")
endmodule
`default_nettype wire

@@ test/ray_box_slab_test_check.sv @@
// checker for the ray/box slab block: watches both channels, predicts hits
// depends on rbst_pkg
`timescale 1ns / 100ps
module ray_box_slab_test_check #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [W-1:0] cfg_data_i,
  input  logic         ray_valid_i,
  input  logic         ray_ready_i,
  input  logic [W-1:0] ox_i, oy_i, oz_i, dx_i, dy_i, dz_i, tn_i, tf_i,
  input  logic         hit_valid_i,
  input  logic         hit_ready_i,
  input  logic         hit_i,
  output int           errors_o,
  output int           pending_o
);
  import rbst_pkg::*;

  localparam longint MAXV = (64'sd1 <<< (W - 1)) - 1;
  localparam longint MINV = -MAXV - 1;

  logic signed [W-1:0] box_lo [3];
  logic signed [W-1:0] box_hi [3];
  bit hit_queue [$];

  function automatic longint clamp(input longint v);
    if (v > MAXV) return MAXV;
    if (v < MINV) return MINV;
    return v;
  endfunction

  // fixed-point product, magnitude truncated toward zero, then saturated
  function automatic longint fx_mul(input longint a, input longint b);
    logic [127:0] p;
    logic [127:0] ma, mb;
    logic [127:0] q;
    bit neg;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    p = ma * mb;
    q = p >> FRAC_BITS;
    if (!neg) return (q > MAXV) ? MAXV : longint'(q);
    if (q > 128'(MAXV) + 1) return MINV;
    return -longint'(q);
  endfunction

  function automatic longint fx_recip(input longint d);
    longint m;
    longint q;
    m = d < 0 ? -d : d;
    q = (64'sd1 <<< (2 * FRAC_BITS)) / m;
    return clamp(d < 0 ? -q : q);
  endfunction

  // false when a parallel slab misses
  function automatic bit slab_span(input int ax, input longint o, input longint d,
                                   output longint t0, output longint t1);
    longint lo, hi, inv, nb, fb;
    lo = box_lo[ax];
    hi = box_hi[ax];
    t0 = MINV;
    t1 = MAXV;
    if (d == 0) return (lo <= o) && (o <= hi);
    inv = fx_recip(d);
    nb = d < 0 ? hi : lo;
    fb = d < 0 ? lo : hi;
    t0 = fx_mul(clamp(nb - o), inv);
    t1 = fx_mul(clamp(fb - o), inv);
    return 1'b1;
  endfunction

  function automatic bit predict_hit(input longint o [3], input longint d [3],
                                     input longint tn, input longint tf);
    longint tmin, tmax, a, b;
    if (!slab_span(0, o[0], d[0], tmin, tmax)) return 1'b0;
    for (int ax = 1; ax < 3; ax++) begin
      if (!slab_span(ax, o[ax], d[ax], a, b)) return 1'b0;
      if (tmin > b || a > tmax) return 1'b0;
      if (a > tmin) tmin = a;
      if (b < tmax) tmax = b;
    end
    return (tmin < tf) && (tmax > tn);
  endfunction

  assign pending_o = hit_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    longint o [3];
    longint d [3];
    bit exp_hit;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        box_lo[i] <= '0;
        box_hi[i] <= '0;
      end
      errors_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LO_X: box_lo[0] <= cfg_data_i;
          REG_LO_Y: box_lo[1] <= cfg_data_i;
          REG_LO_Z: box_lo[2] <= cfg_data_i;
          REG_HI_X: box_hi[0] <= cfg_data_i;
          REG_HI_Y: box_hi[1] <= cfg_data_i;
          REG_HI_Z: box_hi[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (ray_valid_i && ray_ready_i) begin
        o[0] = $signed(ox_i); o[1] = $signed(oy_i); o[2] = $signed(oz_i);
        d[0] = $signed(dx_i); d[1] = $signed(dy_i); d[2] = $signed(dz_i);
        hit_queue.push_back(predict_hit(o, d, $signed(tn_i), $signed(tf_i)));
      end
      if (hit_valid_i && hit_ready_i) begin
        if (hit_queue.size() == 0) begin
          $error("hit transfer with no ray outstanding");
          errors_o <= errors_o + 1;
        end else begin
          exp_hit = hit_queue.pop_front();
          if (hit_i !== exp_hit) begin
            $error("hit mismatch: expected %0d actual %0d", exp_hit, hit_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

@@ test/ray_box_slab_test_tb.sv @@
// stimulus and verdict for the ray/box slab block
// depends on rbst_pkg, rbst_if.sv, the block and ray_box_slab_test_check
`timescale 1ns / 100ps
module ray_box_slab_test_tb;
  import rbst_pkg::*;

  localparam int W = 32;
  localparam int N_RAND = 550;
  localparam longint LIMIT = 400000;
  localparam logic [W-1:0] ONE = 32'h0001_0000;
  localparam logic [W-1:0] MAXW = 32'h7fff_ffff;
  localparam logic [W-1:0] MINW = 32'h8000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [W-1:0] cfg_data_i = '0;
  int errors, pending;
  longint cycles = 0;
  bit in_done = 1'b0;

  rbst_ray_if #(.W(W)) ray_ch ();
  rbst_hit_if hit_ch ();

  ray_box_slab_test #(.COORD_WIDTH(W)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .ray_i(ray_ch.sink), .hit_o(hit_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  ray_box_slab_test_check #(.W(W)) checker_u (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .ray_valid_i(ray_ch.valid), .ray_ready_i(ray_ch.ready),
    .ox_i(ray_ch.origin_x), .oy_i(ray_ch.origin_y), .oz_i(ray_ch.origin_z),
    .dx_i(ray_ch.dir_x), .dy_i(ray_ch.dir_y), .dz_i(ray_ch.dir_z),
    .tn_i(ray_ch.t_near), .tf_i(ray_ch.t_far), .hit_valid_i(hit_ch.valid),
    .hit_ready_i(hit_ch.ready), .hit_i(hit_ch.hit), .errors_o(errors), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    ray_ch.valid = 1'b0;
    {ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z} = '0;
    {ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z, ray_ch.t_near, ray_ch.t_far} = '0;
    hit_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // random receiver stall per result, sometimes long runs with none
  initial begin
    int gap;
    int calm;
    calm = 0;
    @(posedge rst_ni);
    forever begin
      gap = (calm > 0) ? 0 : $urandom_range(0, 12);
      if (calm > 0) calm--;
      else if ($urandom_range(0, 15) == 0) calm = 40;
      if (gap > 0) begin
        hit_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      hit_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(hit_ch.valid && hit_ch.ready));
    end
  end

  logic [W-1:0] ray_buf [8];
  int idle_run = 0;

  task automatic send_ray();
    int gap;
    gap = (idle_run > 0) ? 0 : $urandom_range(0, 12);
    if (idle_run > 0) idle_run--;
    else if ($urandom_range(0, 15) == 0) idle_run = 30;
    if (gap > 0) begin
      ray_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ray_ch.valid <= 1'b1;
    ray_ch.origin_x <= ray_buf[0]; ray_ch.origin_y <= ray_buf[1];
    ray_ch.origin_z <= ray_buf[2]; ray_ch.dir_x <= ray_buf[3];
    ray_ch.dir_y <= ray_buf[4]; ray_ch.dir_z <= ray_buf[5];
    ray_ch.t_near <= ray_buf[6]; ray_ch.t_far <= ray_buf[7];
    do @(posedge clk_i); while (!ray_ch.ready);
  endtask

  task automatic wait_drain();
    ray_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_box(input logic [W-1:0] lx, ly, lz, hx, hy, hz);
    write_reg(REG_LO_X, lx); write_reg(REG_LO_Y, ly); write_reg(REG_LO_Z, lz);
    write_reg(REG_HI_X, hx); write_reg(REG_HI_Y, hy); write_reg(REG_HI_Z, hz);
  endtask

  function automatic logic [W-1:0] pick_val(input int span_lim);
    case ($urandom_range(0, 9))
      0: return MAXW;
      1: return MINW;
      2: return '0;
      3: return $urandom();
      default: return W'($signed($urandom_range(0, 2 * span_lim)) - span_lim);
    endcase
  endfunction

  task automatic rand_ray(input int span);
    for (int i = 0; i < 8; i++) ray_buf[i] = pick_val(span);
    // zero directions now and then for parallel slabs
    for (int i = 3; i < 6; i++) if ($urandom_range(0, 5) == 0) ray_buf[i] = '0;
    if ($urandom_range(0, 3) != 0) begin
      ray_buf[6] = W'($signed($urandom_range(0, 4)) * -32'sh1_0000);
      ray_buf[7] = W'($signed($urandom_range(0, 1 << 22)));
    end
    send_ray();
  endtask

  task automatic direct_ray(input logic [W-1:0] ox, oy, oz, dx, dy, dz, tn, tf);
    ray_buf = '{ox, oy, oz, dx, dy, dz, tn, tf};
    send_ray();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset box: degenerate point at origin
    direct_ray('0, '0, '0, '0, '0, '0, MINW, MAXW);
    direct_ray(ONE, '0, '0, '0, '0, '0, MINW, MAXW);
    wait_drain();

    // unit-ish box from -4 to 4
    set_box(-4 * ONE, -4 * ONE, -4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE);
    write_reg(3'd7, MAXW);
    direct_ray(-10 * ONE, '0, '0, ONE, '0, '0, '0, 100 * ONE);
    direct_ray(-10 * ONE, '0, '0, -ONE, '0, '0, '0, 100 * ONE);
    direct_ray(-10 * ONE, 5 * ONE, '0, ONE, '0, '0, '0, 100 * ONE);
    direct_ray(-10 * ONE, -10 * ONE, -10 * ONE, ONE, ONE, ONE, '0, 100 * ONE);
    direct_ray('0, '0, '0, 32'd1, 32'hffff_ffff, 32'd1, MINW, MAXW);
    direct_ray('0, '0, '0, MAXW, MINW, MAXW, MINW, MAXW);
    direct_ray(MAXW, MINW, MAXW, MINW, MAXW, MINW, '0, MAXW);
    direct_ray(-10 * ONE, '0, '0, ONE, '0, '0, 5 * ONE, 5 * ONE);
    direct_ray(-10 * ONE, '0, '0, ONE, '0, '0, 20 * ONE, ONE);
    direct_ray(-10 * ONE, '0, '0, ONE, '0, '0, MAXW, MINW);
    direct_ray(-10 * ONE, 20 * ONE, '0, ONE, -ONE, '0, '0, 100 * ONE);
    wait_drain();

    // inverted box, then the extremes
    set_box(4 * ONE, 4 * ONE, 4 * ONE, -4 * ONE, -4 * ONE, -4 * ONE);
    direct_ray('0, '0, '0, ONE, ONE, ONE, MINW, MAXW);
    direct_ray('0, '0, '0, '0, ONE, ONE, MINW, MAXW);
    wait_drain();
    set_box(MINW, MINW, MINW, MAXW, MAXW, MAXW);
    direct_ray(MAXW, MINW, '0, '0, '0, '0, MINW, MAXW);
    direct_ray(MINW, MAXW, MAXW, ONE, -ONE, 32'd3, MINW, MAXW);
    direct_ray('0, '0, '0, 32'd1, 32'd1, 32'd1, '0, ONE);
    wait_drain();

    // random phases with differing boxes
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_box(-4 * ONE, -4 * ONE, -4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE);
        1: set_box(-ONE, -2 * ONE, '0, 3 * ONE, 2 * ONE, ONE);
        2: set_box(MINW, MINW, MINW, MAXW, MAXW, MAXW);
        3: set_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        default: set_box(ONE, -ONE, 2 * ONE, -ONE, ONE, 32'h7fff_0000);
      endcase
      for (int n = 0; n < N_RAND / 5; n++) rand_ray(ph == 2 ? 1 << 30 : 16 * ONE);
      wait_drain();
    end
    in_done = 1'b1;
  end

  initial begin
    wait (in_done);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/rbst_pkg.sv
hdl/rbst_if.sv
hdl/rbst_front.sv
hdl/rbst_queue.sv
hdl/rbst_recip.sv
hdl/rbst_back.sv
hdl/ray_box_slab_test.sv
test/ray_box_slab_test_check.sv
test/ray_box_slab_test_tb.sv
